[src/acbc_pkg.sv]
package acbc_pkg;

    localparam int BLK_W = 128;
    localparam int HALF_W = 64;
    localparam int CNT_W = 5;
    localparam int NUM_REGS = 6;
    localparam int IDX_W = 3;
    localparam int RK_DEPTH = 22;
    localparam int RK_AW = 5;

    localparam logic [IDX_W-1:0] REG_KEY_HIGH = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW = 3'd1;
    localparam logic [IDX_W-1:0] REG_IV_HIGH = 3'd2;
    localparam logic [IDX_W-1:0] REG_IV_LOW = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIRECTION = 3'd4;
    localparam logic [IDX_W-1:0] REG_PAD_STYLE = 3'd5;

    localparam logic [7:0] RED_POLY = 8'h1b;
    localparam logic [7:0] PKCS_FULL = 8'h10;
    localparam logic [7:0] RCON_INIT = 8'h01;

    typedef logic [7:0] t_byte;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    typedef struct packed {
        logic [HALF_W-1:0] result_high;
        logic [HALF_W-1:0] result_low;
        logic [CNT_W-1:0]  valid_bytes;
        logic              padding_error;
        logic              end_of_run;
    } t_result;

    typedef struct packed {
        logic [HALF_W-1:0] block_high;
        logic [HALF_W-1:0] block_low;
        logic [CNT_W-1:0]  byte_count;
        logic              first_block;
        logic              final_block;
    } t_request;

    // round unit control from the sequencer
    typedef struct packed {
        logic start;
        logic step;
        logic decrypt;
    } t_rnd_ctl;

    function automatic t_byte xt(input t_byte b);
        return {b[6:0], 1'b0} ^ (b[7] ? RED_POLY : 8'h00);
    endfunction

    // byte i of a 128-bit block, byte 0 in the top bits
    function automatic t_byte byte_at(input logic [BLK_W-1:0] s, input int i);
        return s[BLK_W-1-8*i -: 8];
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        t_byte a [4];
        t_byte x2 [4];
        t_byte x4 [4];
        t_byte x8 [4];
        t_byte m1 [4];
        t_byte m2 [4];
        t_byte m3 [4];
        logic [31:0] o;
        for (int k = 0; k < 4; k++) begin
            a[k] = c[31-8*k -: 8];
            x2[k] = xt(a[k]);
            x4[k] = xt(x2[k]);
            x8[k] = xt(x4[k]);
            // coefficient rows 2,3,1,1 or 14,11,13,9
            m1[k] = inv ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
            m2[k] = inv ? (x8[k] ^ x2[k] ^ a[k]) : (x2[k] ^ a[k]);
            m3[k] = inv ? (x8[k] ^ x4[k] ^ a[k]) : a[k];
        end
        for (int r = 0; r < 4; r++) begin
            o[31-8*r -: 8] = m1[r] ^ m2[(r+1)%4] ^ m3[(r+2)%4]
                             ^ (inv ? (x8[(r+3)%4] ^ a[(r+3)%4]) : a[(r+3)%4]);
        end
        return o;
    endfunction

endpackage

[src/acbc_stream_if.sv]
interface acbc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/acbc_ram.sv]
module acbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/acbc_round.sv]
module acbc_round
    import acbc_pkg::*;
(
    input  logic              i_clk,
    input  t_rnd_ctl          i_ctl,
    input  logic [BLK_W-1:0]  i_load,
    input  logic [BLK_W-1:0]  i_rkey,
    input  logic              i_last,
    output logic [BLK_W-1:0]  o_state
);
    logic [BLK_W-1:0] r_state;
    logic [BLK_W-1:0] n_state;
    logic [BLK_W-1:0] sub;
    logic [BLK_W-1:0] mixed;
    logic [BLK_W-1:0] mix_in;

    always_comb begin
        sub = '0;
        mixed = '0;
        mix_in = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (i_ctl.decrypt) begin
                    sub[BLK_W-1-8*(r+4*((c+r)%4)) -: 8] =
                        INV_SBOX[byte_at(r_state, r+4*c)];
                end else begin
                    sub[BLK_W-1-8*(r+4*c) -: 8] =
                        SBOX[byte_at(r_state, r+4*((c+r)%4))];
                end
            end
        end
        // decrypt: mix after key add; encrypt: mix before key add
        mix_in = i_ctl.decrypt ? (sub ^ i_rkey) : sub;
        for (int c = 0; c < 4; c++) begin
            mixed[BLK_W-1-32*c -: 32] = mix_col(mix_in[BLK_W-1-32*c -: 32], i_ctl.decrypt);
        end
        if (i_ctl.decrypt) begin
            n_state = i_last ? mix_in : mixed;
        end else begin
            n_state = (i_last ? sub : mixed) ^ i_rkey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_state <= i_load ^ i_rkey;
        end else if (i_ctl.step) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
endmodule

[src/acbc_keyexp.sv]
module acbc_keyexp
    import acbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BLK_W-1:0]  i_key,
    output logic              o_busy,
    output logic              o_we,
    output logic [RK_AW-1:0]  o_waddr,
    output logic [HALF_W-1:0] o_wdata
);
    typedef enum logic [1:0] {S_IDLE, S_HIGH, S_LOW} t_state;

    t_state            r_state;
    logic [BLK_W-1:0]  r_key;
    logic [7:0]        r_rcon;
    logic [RK_AW-1:0]  r_addr;
    logic [BLK_W-1:0]  next_key;
    logic [31:0]       t;
    logic [31:0]       w0, w1, w2, w3;

    always_comb begin
        t = {SBOX[r_key[23:16]] ^ r_rcon, SBOX[r_key[15:8]], SBOX[r_key[7:0]],
             SBOX[r_key[31:24]]};
        w0 = r_key[127:96] ^ t;
        w1 = r_key[95:64] ^ w0;
        w2 = r_key[63:32] ^ w1;
        w3 = r_key[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_key <= i_key;
                        r_rcon <= RCON_INIT;
                        r_addr <= '0;
                        r_state <= S_HIGH;
                    end
                end
                S_HIGH: begin
                    r_addr <= r_addr + 1'b1;
                    r_state <= S_LOW;
                end
                S_LOW: begin
                    r_addr <= r_addr + 1'b1;
                    r_key <= next_key;
                    r_rcon <= xt(r_rcon);
                    r_state <= (r_addr == RK_AW'(RK_DEPTH - 1)) ? S_IDLE : S_HIGH;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_we = o_busy;
    assign o_waddr = r_addr;
    assign o_wdata = (r_state == S_HIGH) ? r_key[127:64] : r_key[63:0];
endmodule

[src/aes128_cbc_engine.sv]
// channel   dir  payload                                             handshake
// i_req     in   block_high block_low byte_count first/final_block   valid/ready
// o_res     out  result_high result_low valid_bytes padding_error     valid/ready
//                end_of_run
// i_cfg_*   in   index, 64-bit data                                   write enable
// a block passes a key check, two key reads, an initial key add, 10 rounds (each a key
// read and a round step) and a finish; a full final encrypt block adds a padding block pass
// the first block after a key write first waits for key expansion
// the round unit reads each round key from the 22x64 key memory as two halves
// reset clears control and the chaining value; round keys rebuild on demand
// a held result stalls the next request only until it is taken
module aes128_cbc_engine
    import acbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [HALF_W-1:0]  i_cfg_data,
    acbc_stream_if.sink        i_req,
    acbc_stream_if.source      o_res
);
    typedef enum logic [2:0] {S_IDLE, S_KEYS, S_RD_HI, S_RD_LO, S_ROUND, S_DONE, S_OUT}
        t_state;

    t_state            r_state;
    logic [HALF_W-1:0] r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic              r_direction, r_pad_style, r_keys_ready;
    logic [BLK_W-1:0]  r_chain;
    t_request          r_req;
    logic              r_second;
    logic [3:0]        r_round;
    logic [RK_AW-1:0]  r_raddr;
    logic [HALF_W-1:0] r_rk_hi;
    logic              r_first_key;
    logic              r_out_valid;
    t_result           r_out;

    logic              kx_start, kx_busy, kx_we;
    logic [RK_AW-1:0]  kx_waddr;
    logic [HALF_W-1:0] kx_wdata;
    logic [RK_AW-1:0]  ram_raddr;
    logic [HALF_W-1:0] ram_rdata;
    logic [BLK_W-1:0]  rkey;
    logic [BLK_W-1:0]  aes_state;
    logic [BLK_W-1:0]  load_blk;
    logic [BLK_W-1:0]  in_blk;
    t_rnd_ctl          rctl;
    logic [CNT_W-1:0]  n_cnt;
    logic [BLK_W-1:0]  plain;
    t_byte             last_b;
    logic [BLK_W-1:0]  keep_mask;
    logic              accept;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign n_cnt = (r_req.byte_count > CNT_W'(16)) ? CNT_W'(16) : r_req.byte_count;
    assign rkey = {r_rk_hi, ram_rdata};
    assign kx_start = (r_state == S_KEYS) && !r_keys_ready && !kx_busy;

    acbc_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (kx_start),
        .i_key   ({r_key_high, r_key_low}),
        .o_busy  (kx_busy),
        .o_we    (kx_we),
        .o_waddr (kx_waddr),
        .o_wdata (kx_wdata)
    );

    acbc_ram #(.WIDTH(HALF_W), .DEPTH(RK_DEPTH)) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (kx_we),
        .i_waddr (kx_waddr),
        .i_wdata (kx_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = r_raddr;

    // block entering the cipher
    always_comb begin
        in_blk = {r_req.block_high, r_req.block_low};
        if (r_second) begin
            in_blk = r_pad_style ? {16{PKCS_FULL}} : '0;
        end else if (!r_direction && r_req.final_block) begin
            for (int i = 0; i < 16; i++) begin
                if (CNT_W'(i) >= n_cnt) begin
                    in_blk[BLK_W-1-8*i -: 8] = r_pad_style ? 8'(CNT_W'(16) - n_cnt) : 8'h00;
                end
            end
        end
        load_blk = r_direction ? in_blk : (in_blk ^ r_chain);
    end

    always_comb begin
        rctl.decrypt = r_direction;
        rctl.start = (r_state == S_ROUND) && r_first_key;
        rctl.step = (r_state == S_ROUND) && !r_first_key;
    end

    acbc_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (rctl),
        .i_load  (load_blk),
        .i_rkey  (rkey),
        .i_last  (r_round == 4'd10),
        .o_state (aes_state)
    );

    always_comb begin
        plain = aes_state ^ r_chain;
        last_b = plain[7:0];
        keep_mask = '0;
        for (int i = 0; i < 16; i++) begin
            keep_mask[BLK_W-1-8*i -: 8] = (8'(i) < (8'd16 - last_b)) ? 8'hff : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key_high <= '0;
            r_key_low <= '0;
            r_iv_high <= '0;
            r_iv_low <= '0;
            r_direction <= 1'b0;
            r_pad_style <= 1'b0;
            r_keys_ready <= 1'b0;
            r_chain <= '0;
            r_out_valid <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_KEY_HIGH: begin
                        r_key_high <= i_cfg_data;
                        r_keys_ready <= 1'b0;
                    end
                    REG_KEY_LOW: begin
                        r_key_low <= i_cfg_data;
                        r_keys_ready <= 1'b0;
                    end
                    REG_IV_HIGH: r_iv_high <= i_cfg_data;
                    REG_IV_LOW: r_iv_low <= i_cfg_data;
                    REG_DIRECTION: r_direction <= i_cfg_data[0];
                    REG_PAD_STYLE: r_pad_style <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req <= i_req.data;
                        r_second <= 1'b0;
                        if (i_req.data.first_block) begin
                            r_chain <= {r_iv_high, r_iv_low};
                        end
                        r_state <= S_KEYS;
                    end
                end
                S_KEYS: begin
                    if (r_direction && n_cnt < CNT_W'(16)) begin
                        r_out <= '{result_high: '0, result_low: '0, valid_bytes: '0,
                                   padding_error: 1'b1, end_of_run: 1'b1};
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_keys_ready && !kx_busy) begin
                        r_raddr <= r_direction ? RK_AW'(RK_DEPTH - 2) : '0;
                        r_state <= S_RD_HI;
                    end else if (kx_start) begin
                        r_keys_ready <= 1'b1;
                    end
                end
                S_RD_HI: begin
                    r_raddr <= r_raddr + 1'b1;
                    r_round <= '0;
                    r_first_key <= 1'b1;
                    r_state <= S_RD_LO;
                end
                S_RD_LO: begin
                    r_rk_hi <= ram_rdata;
                    r_raddr <= r_direction ? (r_raddr - RK_AW'(3)) : (r_raddr + 1'b1);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    // low half is on ram_rdata now; set up the next key's two reads
                    r_raddr <= r_raddr + 1'b1;
                    r_first_key <= 1'b0;
                    if (r_first_key) begin
                        r_round <= 4'd1;
                    end else begin
                        r_round <= r_round + 1'b1;
                    end
                    if ((r_round == 4'd10) && !r_first_key) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RD_LO;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out.padding_error <= 1'b0;
                        r_out.end_of_run <= 1'b1;
                        r_out.valid_bytes <= CNT_W'(16);
                        if (!r_direction) begin
                            r_chain <= aes_state;
                            r_out.result_high <= aes_state[127:64];
                            r_out.result_low <= aes_state[63:0];
                            if (r_req.final_block && n_cnt == CNT_W'(16) && !r_second) begin
                                r_out.end_of_run <= 1'b0;
                                r_second <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_chain <= {r_req.block_high, r_req.block_low};
                            r_state <= S_IDLE;
                            if (!r_req.final_block) begin
                                r_out.result_high <= plain[127:64];
                                r_out.result_low <= plain[63:0];
                            end else if (last_b == 8'd16) begin
                                r_out.result_high <= '0;
                                r_out.result_low <= '0;
                                r_out.valid_bytes <= '0;
                            end else if (last_b < 8'd16) begin
                                r_out.result_high <= plain[127:64] & keep_mask[127:64];
                                r_out.result_low <= plain[63:0] & keep_mask[63:0];
                                r_out.valid_bytes <= CNT_W'(8'd16 - last_b);
                            end else begin
                                r_out.result_high <= '0;
                                r_out.result_low <= '0;
                                r_out.valid_bytes <= '0;
                                r_out.padding_error <= 1'b1;
                            end
                        end
                    end
                end
                S_OUT: begin
                    r_raddr <= '0;
                    r_state <= S_RD_HI;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data = r_out;

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != S_IDLE) |-> !i_req.ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("request taken while busy");

    property p_keys_before_round;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_RD_HI) |-> !kx_busy;
    endproperty
    a_keys_before_round: assert property (p_keys_before_round)
        else $error("round key read during expansion");

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_valid && !o_res.ready) |=> r_out_valid && $stable(r_out);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result lost while stalled");
endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import acbc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_index;
    logic [HALF_W-1:0] i_cfg_data;

    acbc_stream_if #(.T(t_request)) req_if ();
    acbc_stream_if #(.T(t_result)) res_if ();

    aes128_cbc_engine dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_req(req_if.sink),
        .o_res(res_if.source)
    );

    // predictor state
    logic [127:0] key_q, iv_q, chain_q;
    logic dec_q, pkcs_q;
    logic [127:0] rkeys [11];

    t_request pending_q [$];
    t_result cipher_out_q [$];
    int n_errors = 0;
    int n_results = 0;
    int n_sent = 0;
    bit idle_allowed = 1'b1;
    bit hold_req = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    function automatic t_byte gf_mul(input t_byte b, input int m);
        t_byte r;
        r = 8'h00;
        for (int i = 0; i < 4; i++) begin
            if (m[i]) r ^= b;
            b = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [127:0] xor_key(input logic [127:0] s, input int r);
        return s ^ rkeys[r];
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? r + 4 * ((c - r + 4) % 4) : r + 4 * ((c + r) % 4);
                o[127-8*(r+4*c) -: 8] = inv ? INV_SBOX[s[127-8*src -: 8]]
                                            : SBOX[s[127-8*src -: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_all(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        int coef [4];
        t_byte v;
        if (inv) coef = '{14, 11, 13, 9};
        else coef = '{2, 3, 1, 1};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v ^= gf_mul(s[127-8*(4*c+k) -: 8], coef[(k - r + 4) % 4]);
                o[127-8*(4*c+r) -: 8] = v;
            end
        end
        return o;
    endfunction

    task automatic build_round_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        t_byte rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = key_q[127-32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {SBOX[t[23:16]] ^ rc, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    function automatic logic [127:0] aes_encrypt(input logic [127:0] s);
        s = xor_key(s, 0);
        for (int r = 1; r <= 10; r++) begin
            s = sub_shift(s, 1'b0);
            if (r < 10) s = mix_all(s, 1'b0);
            s = xor_key(s, r);
        end
        return s;
    endfunction

    function automatic logic [127:0] aes_decrypt(input logic [127:0] s);
        s = xor_key(s, 10);
        for (int r = 9; r >= 0; r--) begin
            s = sub_shift(s, 1'b1);
            s = xor_key(s, r);
            if (r > 0) s = mix_all(s, 1'b1);
        end
        return s;
    endfunction

    function automatic t_result make_out(input logic [127:0] b, input int vb, input bit err,
                                         input bit last);
        t_result o;
        o.result_high = b[127:64];
        o.result_low = b[63:0];
        o.valid_bytes = vb[CNT_W-1:0];
        o.padding_error = err;
        o.end_of_run = last;
        return o;
    endfunction

    task automatic predict_block(input t_request q);
        logic [127:0] b, p;
        int n, keep;
        t_byte pb;
        n = (q.byte_count > 16) ? 16 : q.byte_count;
        if (q.first_block) chain_q = iv_q;
        b = {q.block_high, q.block_low};
        if (!dec_q) begin
            if (q.final_block)
                for (int i = n; i < 16; i++)
                    b[127-8*i -: 8] = pkcs_q ? t_byte'(16 - n) : 8'h00;
            chain_q = aes_encrypt(b ^ chain_q);
            if (q.final_block && n == 16) begin
                cipher_out_q.push_back(make_out(chain_q, 16, 1'b0, 1'b0));
                b = pkcs_q ? {16{PKCS_FULL}} : '0;
                chain_q = aes_encrypt(b ^ chain_q);
            end
            cipher_out_q.push_back(make_out(chain_q, 16, 1'b0, 1'b1));
        end else if (n < 16) begin
            cipher_out_q.push_back(make_out('0, 0, 1'b1, 1'b1));
        end else begin
            p = aes_decrypt(b) ^ chain_q;
            chain_q = b;
            pb = p[7:0];
            if (!q.final_block) begin
                cipher_out_q.push_back(make_out(p, 16, 1'b0, 1'b1));
            end else if (pb == 8'd16) begin
                cipher_out_q.push_back(make_out('0, 0, 1'b0, 1'b1));
            end else if (pb < 8'd16) begin
                keep = 16 - pb;
                for (int i = keep; i < 16; i++) p[127-8*i -: 8] = 8'h00;
                cipher_out_q.push_back(make_out(p, keep, 1'b0, 1'b1));
            end else begin
                cipher_out_q.push_back(make_out('0, 0, 1'b1, 1'b1));
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_block(req_if.data);
                n_sent++;
                void'(pending_q.pop_front());
            end
            if (req_if.valid && !(req_if.ready)) begin
                // hold the current request
            end else if (hold_req || pending_q.size() == 0
                         || (req_if.valid && req_if.ready && pending_q.size() == 0)) begin
                req_if.valid <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap--;
                req_if.valid <= 1'b0;
            end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 7) - 1;
                req_if.valid <= 1'b0;
            end else begin
                req_if.valid <= 1'b1;
                req_if.data <= pending_q[0];
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                n_results++;
                if (cipher_out_q.size() == 0) begin
                    $error("unexpected result %h", got);
                    n_errors++;
                end else begin
                    exp_r = cipher_out_q.pop_front();
                    if (got.result_high !== exp_r.result_high) begin
                        $error("result_high exp %h got %h", exp_r.result_high, got.result_high);
                        n_errors++;
                    end
                    if (got.result_low !== exp_r.result_low) begin
                        $error("result_low exp %h got %h", exp_r.result_low, got.result_low);
                        n_errors++;
                    end
                    if (got.valid_bytes !== exp_r.valid_bytes) begin
                        $error("valid_bytes exp %0d got %0d", exp_r.valid_bytes,
                               got.valid_bytes);
                        n_errors++;
                    end
                    if (got.padding_error !== exp_r.padding_error) begin
                        $error("padding_error exp %b got %b", exp_r.padding_error,
                               got.padding_error);
                        n_errors++;
                    end
                    if (got.end_of_run !== exp_r.end_of_run) begin
                        $error("end_of_run exp %b got %b", exp_r.end_of_run, got.end_of_run);
                        n_errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 7) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_KEY_HIGH: key_q[127:64] = val;
            REG_KEY_LOW: key_q[63:0] = val;
            REG_IV_HIGH: iv_q[127:64] = val;
            REG_IV_LOW: iv_q[63:0] = val;
            REG_DIRECTION: dec_q = val[0];
            REG_PAD_STYLE: pkcs_q = val[0];
            default: ;
        endcase
        if (idx == REG_KEY_HIGH || idx == REG_KEY_LOW) build_round_keys();
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || req_if.valid || cipher_out_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [HALF_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic set_phase(input logic [127:0] k, input logic [127:0] iv, input bit dec,
                             input bit pkcs);
        write_reg(REG_KEY_HIGH, k[127:64]);
        write_reg(REG_KEY_LOW, k[63:0]);
        write_reg(REG_IV_HIGH, iv[127:64]);
        write_reg(REG_IV_LOW, iv[63:0]);
        write_reg(REG_DIRECTION, HALF_W'(dec));
        write_reg(REG_PAD_STYLE, HALF_W'(pkcs));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_request make_req(input logic [127:0] b, input int cnt,
                                          input bit first, input bit last);
        t_request q;
        q.block_high = b[127:64];
        q.block_low = b[63:0];
        q.byte_count = cnt[CNT_W-1:0];
        q.first_block = first;
        q.final_block = last;
        return q;
    endfunction

    // well-formed message of random length, optionally with a corrupt count
    task automatic queue_message(input bit dec);
        int len, cnt;
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
            cnt = 16;
            if (i == len - 1 && !dec) cnt = $urandom_range(0, 16);
            if ($urandom_range(0, 19) == 0) cnt = $urandom_range(0, 31);
            pending_q.push_back(make_req({rand64(), rand64()}, cnt, i == 0, i == len - 1));
        end
    endtask

    // encrypt a random message through the predictor copy and queue its ciphertext
    task automatic queue_cipher_message(input logic [127:0] iv);
        logic [127:0] c, b;
        int len, pad;
        len = $urandom_range(1, 4);
        c = iv;
        for (int i = 0; i < len; i++) begin
            b = {rand64(), rand64()};
            if (i == len - 1) begin
                pad = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 16);
                b[7:0] = pad[7:0];
            end
            c = aes_encrypt(b ^ c);
            pending_q.push_back(make_req(c, 16, i == 0, i == len - 1));
        end
    endtask

    initial begin
        logic [127:0] k, iv;
        int phase;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        key_q = '0;
        iv_q = '0;
        chain_q = '0;
        dec_q = 1'b0;
        pkcs_q = 1'b0;
        build_round_keys();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, both fills, every decrypt padding case
        set_phase('1, '0, 1'b0, 1'b0);
        pending_q.push_back(make_req('0, 16, 1, 0));
        pending_q.push_back(make_req('1, 0, 0, 1));
        pending_q.push_back(make_req('1, 16, 1, 1));
        pending_q.push_back(make_req('0, 31, 1, 1));
        drain();
        set_phase('0, '1, 1'b0, 1'b1);
        pending_q.push_back(make_req('1, 5, 1, 1));
        pending_q.push_back(make_req('0, 16, 1, 1));
        pending_q.push_back(make_req('1, 15, 0, 1));
        drain();
        k = {rand64(), rand64()};
        iv = {rand64(), rand64()};
        set_phase(k, iv, 1'b1, 1'b1);
        for (int pad = 0; pad < 4; pad++) begin
            logic [127:0] b;
            b = '1;
            b[7:0] = (pad == 0) ? 8'd0 : (pad == 1) ? 8'd16 : (pad == 2) ? 8'd7 : 8'd17;
            pending_q.push_back(make_req(aes_encrypt(b ^ iv), 16, 1, 1));
        end
        pending_q.push_back(make_req('1, 3, 1, 0));
        pending_q.push_back(make_req('0, 16, 1, 0));
        pending_q.push_back(make_req('1, 20, 0, 1));
        drain();

        // random phases, pausing until drained between settings
        for (phase = 0; phase < 12; phase++) begin
            k = {rand64(), rand64()};
            iv = {rand64(), rand64()};
            set_phase(k, iv, phase[0], phase[1]);
            if (phase == 11) idle_allowed = 1'b0;
            while (pending_q.size() < 80) begin
                if (!phase[0]) queue_message(1'b0);
                else if ($urandom_range(0, 4) == 0) queue_message(1'b1);
                else queue_cipher_message(iv);
            end
            if (phase == 4) begin
                while (pending_q.size() > 40) @(posedge i_clk);
                hold_req = 1'b1;
                while (cipher_out_q.size() != 0 || req_if.valid) @(posedge i_clk);
                hold_req = 1'b0;
            end
            drain();
        end

        $display("sent %0d blocks, checked %0d results over encrypt and decrypt phases",
                 n_sent, n_results);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[sim.f]
src/acbc_pkg.sv
src/acbc_stream_if.sv
src/acbc_ram.sv
src/acbc_round.sv
src/acbc_keyexp.sv
src/aes128_cbc_engine.sv
tb/sv/tb_top.sv
